>>> rtl/core/kph_pkg.sv
// Shared types and constants for the polynomial hash over GF(2^61-1).
// No dependencies.
package kph_pkg;
   localparam int KEY_W   = 64;
   localparam int FIELD_W = 61;
   localparam int COEF_COUNT = 8;
   localparam int INDEX_W = 3;
   localparam int HALF_W  = 31;
   localparam logic [FIELD_W-1:0] PRIME = {FIELD_W{1'b1}};

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [INDEX_W-1:0] index_type;
endpackage

>>> rtl/core/kph_if.sv
// Valid/ready stream interfaces for the hash request and response items.
// Depends on kph_pkg.
interface kph_req_if;
   import kph_pkg::*;
   logic    valid;
   logic    ready;
   key_type item_key;
   modport source (output valid, output item_key, input ready);
   modport sink   (input valid, input item_key, output ready);
endinterface

interface kph_rsp_if;
   import kph_pkg::*;
   logic      valid;
   logic      ready;
   field_type hash_value;
   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

>>> rtl/core/kph_key.sv
// Two-stage reduction of a signed 64-bit key into the field [0, 2^61-1).
// Depends on kph_pkg.
module kph_key
   import kph_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  key_type   in_key,
   output logic      out_valid,
   input  logic      out_ready,
   output field_type out_x
);
   logic                 s1_valid_ff, s2_valid_ff;
   logic                 s1_ready, s2_ready;
   logic                 neg_ff;
   logic [FIELD_W:0]     fold_ff, fold_in;
   field_type            x_ff, x_in;
   key_type              mag;
   field_type            m;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      mag     = in_key[KEY_W-1] ? (~in_key + key_type'(1)) : in_key;
      fold_in = {1'b0, mag[FIELD_W-1:0]} + (FIELD_W+1)'(mag[KEY_W-1:FIELD_W]);
      m       = (fold_ff >= {1'b0, PRIME}) ? FIELD_W'(fold_ff - {1'b0, PRIME})
                                           : fold_ff[FIELD_W-1:0];
      x_in    = (neg_ff && m != '0) ? PRIME - m : m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_ready && in_valid) begin
         fold_ff <= fold_in;
         neg_ff  <= in_key[KEY_W-1];
      end
      if (s2_ready && s1_valid_ff) x_ff <= x_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_x     = x_ff;
endmodule

>>> rtl/core/kph_step.sv
// One Horner step acc*x + coef mod 2^61-1 in three stages:
// partial products, sum and fold, final reduce and add. Depends on kph_pkg.
module kph_step
   import kph_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  field_type in_acc,
   input  field_type in_x,
   input  field_type coef,
   output logic      out_valid,
   input  logic      out_ready,
   output field_type out_acc,
   output field_type out_x
);
   localparam int PP_W   = 2 * HALF_W;
   localparam int PROD_W = 2 * FIELD_W;

   logic                 v1_ff, v2_ff, v3_ff;
   logic                 r1, r2, r3;
   logic [PP_W-1:0]      pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   field_type            x1_ff, x2_ff, x3_ff;
   logic [FIELD_W:0]     r_ff, r_in;
   field_type            acc_ff, acc_in;
   logic [HALF_W-1:0]    a0, a1, b0, b1;
   logic [PROD_W-1:0]    prod;
   field_type            t;
   logic [FIELD_W:0]     s;

   assign r3 = !v3_ff || out_ready;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      a0 = in_acc[HALF_W-1:0];
      a1 = HALF_W'(in_acc[FIELD_W-1:HALF_W]);
      b0 = in_x[HALF_W-1:0];
      b1 = HALF_W'(in_x[FIELD_W-1:HALF_W]);
      prod = PROD_W'(pp00_ff)
           + (PROD_W'(pp01_ff) << HALF_W)
           + (PROD_W'(pp10_ff) << HALF_W)
           + (PROD_W'(pp11_ff) << (2 * HALF_W));
      r_in = {1'b0, prod[FIELD_W-1:0]} + {1'b0, prod[PROD_W-1:FIELD_W]};
      t = (r_ff >= {1'b0, PRIME}) ? FIELD_W'(r_ff - {1'b0, PRIME}) : r_ff[FIELD_W-1:0];
      s = {1'b0, t} + {1'b0, coef};
      acc_in = (s >= {1'b0, PRIME}) ? FIELD_W'(s - {1'b0, PRIME}) : s[FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
      if (r1 && in_valid) begin
         pp00_ff <= a0 * b0;
         pp01_ff <= a0 * b1;
         pp10_ff <= a1 * b0;
         pp11_ff <= a1 * b1;
         x1_ff   <= in_x;
      end
      if (r2 && v1_ff) begin
         r_ff  <= r_in;
         x2_ff <= x1_ff;
      end
      if (r3 && v2_ff) begin
         acc_ff <= acc_in;
         x3_ff  <= x2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_acc   = acc_ff;
   assign out_x     = x3_ff;
endmodule

>>> rtl/core/kwise_polynomial_hash.sv
// Polynomial hash of a signed 64-bit key over GF(2^61-1), Horner form.
// From request to response the pipeline holds
// 2 key-reduction stages, 3 stages per Horner step, 1 output register.
// Throughput: one item per cycle; every stage holds under backpressure.
// Reset clears all valid bits and the coefficients to zero.
// Depends on kph_pkg, kph_if, kph_key and kph_step.
module kwise_polynomial_hash
   import kph_pkg::*;
#(
   parameter int NUM_COEFFS = 8
)(
   input  logic      clock,
   input  logic      reset,
   kph_req_if.sink   req_chan,
   kph_rsp_if.source rsp_chan,
   input  logic      csr_we,
   input  index_type csr_index,
   input  field_type csr_wdata
);
   field_type coef_ff [COEF_COUNT];
   logic      ch_valid [NUM_COEFFS];
   logic      ch_ready [NUM_COEFFS];
   field_type ch_acc   [NUM_COEFFS];
   field_type ch_x     [NUM_COEFFS];
   logic      rsp_valid_ff;
   field_type rsp_hash_ff;
   logic      rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) coef_ff[i] <= '0;
      end else if (csr_we) begin
         coef_ff[csr_index] <= (csr_wdata == PRIME) ? '0 : csr_wdata;
      end
   end

   kph_key u_key (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_key    (req_chan.item_key),
      .out_valid (ch_valid[0]),
      .out_ready (ch_ready[0]),
      .out_x     (ch_x[0])
   );
   assign ch_acc[0] = coef_ff[NUM_COEFFS-1];

   for (genvar j = 0; j < NUM_COEFFS - 1; j++) begin : g_step
      kph_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[j]),
         .in_ready  (ch_ready[j]),
         .in_acc    (ch_acc[j]),
         .in_x      (ch_x[j]),
         .coef      (coef_ff[NUM_COEFFS-2-j]),
         .out_valid (ch_valid[j+1]),
         .out_ready (ch_ready[j+1]),
         .out_acc   (ch_acc[j+1]),
         .out_x     (ch_x[j+1])
      );
   end

   assign ch_ready[NUM_COEFFS-1] = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = ch_ready[NUM_COEFFS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= ch_valid[NUM_COEFFS-1];
      end
      if (rsp_load && ch_valid[NUM_COEFFS-1]) rsp_hash_ff <= ch_acc[NUM_COEFFS-1];
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;
endmodule
